@@ src/ucb_pkg.sv @@
// ============================================================================
// ucb_pkg
// Shared types and constants of the UART command and bridge line processor.
// ============================================================================
`default_nettype none

package ucb_pkg;

    localparam int CMD_DEPTH_DEF = 32;
    localparam int BL_DEPTH_DEF  = 32;

    localparam logic [15:0] TIMEOUT_RST = 16'd200;
    localparam int          PFX_LEN     = 7;
    localparam logic [1:0]  PLUS_SAT    = 2'd3;

    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_PLUS = 8'd43;

    typedef enum logic [2:0] {
        EV_BYTE       = 3'd0,
        EV_START      = 3'd1,
        EV_STOP       = 3'd2,
        EV_BRIDGE_ON  = 3'd3,
        EV_BRIDGE_OFF = 3'd4,
        EV_DROP       = 3'd5
    } t_evt;

    typedef struct packed {
        logic       accept;
        logic       action;
        logic [7:0] rx_data;
        logic       rd_next;
    } t_cmd;

    typedef struct packed {
        logic       ev_valid;
        t_evt       ev_kind;
        logic       flush;
        logic [7:0] rd_byte;
        logic       rd_last;
    } t_sts;

endpackage

`default_nettype wire

@@ src/ucb_if.sv @@
// ============================================================================
// ucb_in_if / ucb_out_if
// Request and result channels with valid/ready handshake.
// ============================================================================
`default_nettype none

interface ucb_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] rx_data;

    modport source (output valid, action, rx_data, input ready);
    modport sink   (input valid, action, rx_data, output ready);
endinterface

interface ucb_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, event_kind, out_byte, last, input ready);
    modport sink   (input valid, event_kind, out_byte, last, output ready);
endinterface

`default_nettype wire

@@ src/ucb_datapath.sv @@
// ============================================================================
// ucb_datapath
// Line state, command prefix, bridge line memory and idle timer.
// ============================================================================
`default_nettype none

module ucb_datapath import ucb_pkg::*; #(
    parameter int COMMAND_DEPTH     = CMD_DEPTH_DEF,
    parameter int BRIDGE_LINE_DEPTH = BL_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts
);

    localparam int CL_W = $clog2(COMMAND_DEPTH);
    localparam int BL_W = $clog2(BRIDGE_LINE_DEPTH);

    logic [15:0]     r_timeout;
    logic            r_mode,     n_mode;
    logic [CL_W-1:0] r_cmd_len,  n_cmd_len;
    logic [7:0]      r_pfx [PFX_LEN];
    logic [7:0]      n_pfx [PFX_LEN];
    logic [BL_W-1:0] r_bl_len,   n_bl_len;
    logic [1:0]      r_plus,     n_plus;
    logic            r_skip,     n_skip;
    logic [15:0]     r_idle,     n_idle;
    logic            r_ev_valid, n_ev_valid;
    t_evt            r_ev_kind,  n_ev_kind;
    logic            r_flush,    n_flush;
    logic [BL_W-1:0] r_flush_len, n_flush_len;
    logic [BL_W-1:0] r_rd_idx;
    logic [7:0]      r_rd_data;
    logic [7:0]      r_mem [BRIDGE_LINE_DEPTH];

    logic            mem_we;
    logic            mem_re;
    logic [BL_W-1:0] rd_addr;
    logic            do_run;
    logic [CL_W-1:0] run_len;
    logic [1:0]      plus_inc;
    logic [7:0]      b;

    assign b = i_cmd.rx_data;

    always_comb begin
        n_mode      = r_mode;
        n_cmd_len   = r_cmd_len;
        n_pfx       = r_pfx;
        n_bl_len    = r_bl_len;
        n_plus      = r_plus;
        n_skip      = r_skip;
        n_idle      = r_idle;
        n_ev_valid  = r_ev_valid;
        n_ev_kind   = r_ev_kind;
        n_flush     = r_flush;
        n_flush_len = r_flush_len;
        mem_we      = 1'b0;
        do_run      = 1'b0;
        run_len     = r_cmd_len;
        plus_inc    = 2'd0;

        if (i_cmd.accept) begin
            n_ev_valid = 1'b0;
            n_ev_kind  = EV_BYTE;
            n_flush    = 1'b0;
            if (!i_cmd.action) begin
                if (r_mode) begin
                    if (b == CH_LF && r_skip) begin
                        n_skip = 1'b0;
                    end else if (b == CH_CR || b == CH_LF) begin
                        n_skip = (b == CH_CR);
                        if (r_bl_len != '0) begin
                            n_flush     = 1'b1;
                            n_flush_len = r_bl_len;
                            n_plus      = 2'd0;
                            n_bl_len    = '0;
                        end
                    end else begin
                        n_skip = 1'b0;
                        if (b == CH_PLUS) begin
                            plus_inc = (r_plus == PLUS_SAT) ? r_plus : r_plus + 2'd1;
                        end
                        if (r_bl_len < BL_W'(BRIDGE_LINE_DEPTH - 1)) begin
                            mem_we   = 1'b1;
                            n_bl_len = r_bl_len + 1'b1;
                            if (plus_inc == PLUS_SAT && r_bl_len == BL_W'(2)) begin
                                n_plus     = 2'd0;
                                n_bl_len   = '0;
                                n_mode     = 1'b0;
                                n_ev_valid = 1'b1;
                                n_ev_kind  = EV_BRIDGE_OFF;
                            end else begin
                                n_plus = plus_inc;
                            end
                        end else begin
                            n_bl_len   = '0;
                            n_plus     = 2'd0;
                            n_ev_valid = 1'b1;
                            n_ev_kind  = EV_DROP;
                        end
                    end
                end else if (r_cmd_len < CL_W'(COMMAND_DEPTH - 1)) begin
                    for (int i = 0; i < PFX_LEN; i++) begin
                        if (r_cmd_len == CL_W'(i)) begin
                            n_pfx[i] = b;
                        end
                    end
                    n_cmd_len = r_cmd_len + 1'b1;
                    n_idle    = '0;
                    if (b == CH_CR || b == CH_LF) begin
                        do_run  = 1'b1;
                        run_len = r_cmd_len;
                    end else if (n_cmd_len == CL_W'(COMMAND_DEPTH - 1)) begin
                        do_run  = 1'b1;
                        run_len = n_cmd_len;
                    end
                end
            end else if (r_cmd_len != '0) begin
                n_idle = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
                if (n_idle >= r_timeout) begin
                    do_run  = 1'b1;
                    run_len = r_cmd_len;
                end
            end

            if (do_run) begin
                n_cmd_len = '0;
                n_idle    = '0;
                if (run_len == CL_W'(5) &&
                    {n_pfx[0], n_pfx[1], n_pfx[2], n_pfx[3], n_pfx[4]} == "start") begin
                    n_ev_valid = 1'b1;
                    n_ev_kind  = EV_START;
                end else if (run_len == CL_W'(4) &&
                    {n_pfx[0], n_pfx[1], n_pfx[2], n_pfx[3]} == "stop") begin
                    n_ev_valid = 1'b1;
                    n_ev_kind  = EV_STOP;
                end else if ((run_len == CL_W'(3) &&
                              {n_pfx[0], n_pfx[1], n_pfx[2]} == "esp") ||
                             (run_len == CL_W'(6) &&
                              {n_pfx[0], n_pfx[1], n_pfx[2], n_pfx[3], n_pfx[4],
                               n_pfx[5]} == "esp_on") ||
                             (run_len == CL_W'(2) &&
                              {n_pfx[0], n_pfx[1]} == "at")) begin
                    n_plus     = 2'd0;
                    n_skip     = 1'b0;
                    n_bl_len   = '0;
                    n_mode     = 1'b1;
                    n_ev_valid = 1'b1;
                    n_ev_kind  = EV_BRIDGE_ON;
                end else if (run_len == CL_W'(7) &&
                    {n_pfx[0], n_pfx[1], n_pfx[2], n_pfx[3], n_pfx[4], n_pfx[5],
                     n_pfx[6]} == "esp_off") begin
                    n_plus     = 2'd0;
                    n_skip     = 1'b0;
                    n_bl_len   = '0;
                    n_mode     = 1'b0;
                    n_ev_valid = 1'b1;
                    n_ev_kind  = EV_BRIDGE_OFF;
                end
            end
        end
    end

    assign mem_re  = i_cmd.accept || i_cmd.rd_next;
    assign rd_addr = i_cmd.accept ? '0 : r_rd_idx + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= TIMEOUT_RST;
            r_mode     <= 1'b0;
            r_cmd_len  <= '0;
            r_bl_len   <= '0;
            r_plus     <= 2'd0;
            r_skip     <= 1'b0;
            r_idle     <= '0;
            r_ev_valid <= 1'b0;
            r_ev_kind  <= EV_BYTE;
            r_flush    <= 1'b0;
            r_rd_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            r_mode     <= n_mode;
            r_cmd_len  <= n_cmd_len;
            r_bl_len   <= n_bl_len;
            r_plus     <= n_plus;
            r_skip     <= n_skip;
            r_idle     <= n_idle;
            r_ev_valid <= n_ev_valid;
            r_ev_kind  <= n_ev_kind;
            r_flush    <= n_flush;
            if (mem_re) begin
                r_rd_idx <= rd_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfx       <= n_pfx;
        r_flush_len <= n_flush_len;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_bl_len] <= b;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_sts.ev_valid = r_ev_valid;
    assign o_sts.ev_kind  = r_ev_kind;
    assign o_sts.flush    = r_flush;
    assign o_sts.rd_byte  = r_rd_data;
    assign o_sts.rd_last  = (r_rd_idx == r_flush_len - 1'b1);

    a_cmd_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd_len < CL_W'(COMMAND_DEPTH - 1))
        else $error("command length reached full store at rest");

    a_plus_le_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        BL_W'(r_plus) <= r_bl_len)
        else $error("plus run longer than bridge line");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flush |-> r_flush_len != '0)
        else $error("flush of empty bridge line");

endmodule

`default_nettype wire

@@ src/ucb_ctrl.sv @@
// ============================================================================
// ucb_ctrl
// Request handshake, result sequencing and output register.
// ============================================================================
`default_nettype none

module ucb_ctrl import ucb_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ucb_in_if.sink      i_req,
    ucb_out_if.source   o_rsp,
    input  wire t_sts   i_sts,
    output t_cmd        o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_BYTES,
        S_CR,
        S_LF
    } t_state;

    t_state     r_state;
    logic       r_out_valid;
    t_evt       r_out_kind;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic accept;
    logic slot_free;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign slot_free   = !r_out_valid || o_rsp.ready;

    assign o_cmd.accept  = accept;
    assign o_cmd.action  = i_req.action;
    assign o_cmd.rx_data = i_req.rx_data;
    assign o_cmd.rd_next = (r_state == S_BYTES) && slot_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_out_kind  <= EV_BYTE;
            r_out_byte  <= '0;
            r_out_last  <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (i_sts.flush) begin
                        r_state <= S_BYTES;
                    end else if (!i_sts.ev_valid) begin
                        r_state <= S_IDLE;
                    end else if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= i_sts.ev_kind;
                        r_out_byte  <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_BYTES: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= EV_BYTE;
                        r_out_byte  <= i_sts.rd_byte;
                        r_out_last  <= 1'b0;
                        if (i_sts.rd_last) begin
                            r_state <= S_CR;
                        end
                    end
                end
                S_CR: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= EV_BYTE;
                        r_out_byte  <= CH_CR;
                        r_out_last  <= 1'b0;
                        r_state     <= S_LF;
                    end
                end
                S_LF: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_kind  <= EV_BYTE;
                        r_out_byte  <= CH_LF;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.event_kind = r_out_kind;
    assign o_rsp.out_byte   = r_out_byte;
    assign o_rsp.last       = r_out_last;

    a_bytes_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BYTES) |-> i_sts.flush)
        else $error("byte drain without a pending flush");

    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECIDE))
        else $error("accepted request not decoded");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=>
        (r_out_valid && $stable(r_out_kind) && $stable(r_out_byte) && $stable(r_out_last)))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

@@ src/uart_command_and_bridge_line_processor_unit.sv @@
// ============================================================================
// uart_command_and_bridge_line_processor_unit
// UART command matcher and line bridge, top level.
// ============================================================================
// Request channel i_req: action 0 carries a received UART byte in rx_data,
// action 1 is a one millisecond tick. Result channel o_rsp: event_kind with
// out_byte for forwarded bytes; last marks the final result of a request.
// i_cfg_we / i_cfg_wdata write the idle timeout in ticks (reset 200).
// A request is decoded in the cycle after it is taken. A request that
// gives no result then returns to idle; a single event waits only for
// the output register. A bridge line drains from the line memory through
// its single read port at one byte per cycle while the output register
// is free, followed by CR and LF.
// No new request is taken until the current one's results are all loaded
// into the output register; the last result may still wait there while
// the next request is accepted. A stalled receiver simply holds o_rsp.
// Reset returns to command mode with empty lines and the timeout at 200;
// no clearing pass is needed.
// ============================================================================
`default_nettype none

module uart_command_and_bridge_line_processor_unit import ucb_pkg::*; #(
    parameter int COMMAND_DEPTH     = CMD_DEPTH_DEF,
    parameter int BRIDGE_LINE_DEPTH = BL_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    ucb_in_if.sink           i_req,
    ucb_out_if.source        o_rsp
);

    t_cmd cmd;
    t_sts sts;

    ucb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ucb_datapath #(
        .COMMAND_DEPTH     (COMMAND_DEPTH),
        .BRIDGE_LINE_DEPTH (BRIDGE_LINE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

`default_nettype wire

@@ bench/uart_command_and_bridge_line_processor_unit_test.sv @@
// ============================================================================
// uart_command_and_bridge_line_processor_unit_test
// Self-checking bench for the UART command matcher and line bridge.
// ============================================================================
// Bytes and ticks go into the request channel. A model of the command and
// bridge line state predicts each result, and the results are checked in
// order. Directed tests cover command words, bridge lines, +++ and the
// idle timeout. Random traffic then runs under several timeout settings,
// with random stalls on both channels, except in the run after the long timeout.
// ============================================================================

module uart_command_and_bridge_line_processor_unit_test;
    import ucb_pkg::*;

    localparam int   CMD_DEPTH      = CMD_DEPTH_DEF;
    localparam int   LINE_DEPTH     = BL_DEPTH_DEF;
    localparam logic ACT_BYTE       = 1'b0;
    localparam logic ACT_TICK       = 1'b1;
    localparam int   SETTLE_CYCLES  = 20;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   IDLE_CNT_MAX   = 65535;

    typedef enum int {
        EOL_CR,
        EOL_LF,
        EOL_CRLF
    } t_eol;

    typedef struct packed {
        t_evt       kind;
        logic [7:0] data;
        logic       last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    ucb_in_if  req_if ();
    ucb_out_if rsp_if ();

    uart_command_and_bridge_line_processor_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    // line processor state
    logic        br_mode;
    logic [7:0]  cmd_mem [CMD_DEPTH];
    int          cmd_len;
    logic [7:0]  line_mem [LINE_DEPTH];
    int          line_len;
    int          plus_cnt;
    logic        skip_lf;
    int          idle_cnt;
    int          idle_limit;

    t_result     expected_q [$];
    t_result     req_results [$];
    int          err_cnt;
    int          sent_cnt;
    int          quiet_cnt;
    bit          idle_en;
    string       cmd_words [6] = '{"start", "stop", "esp", "esp_on", "at", "esp_off"};

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void push_event(t_evt kind, logic [7:0] data);
        t_result r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        req_results.push_back(r);
    endfunction

    function automatic bit word_match(string w, int len);
        if (len != w.len()) return 1'b0;
        for (int i = 0; i < len; i++) begin
            if (cmd_mem[i] != w[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void reset_line_state();
        plus_cnt = 0;
        skip_lf  = 1'b0;
        line_len = 0;
    endfunction

    function automatic void finish_command(int len);
        cmd_len  = 0;
        idle_cnt = 0;
        if (word_match("start", len)) begin
            push_event(EV_START, 8'd0);
        end else if (word_match("stop", len)) begin
            push_event(EV_STOP, 8'd0);
        end else if (word_match("esp", len) || word_match("esp_on", len) ||
                     word_match("at", len)) begin
            reset_line_state();
            br_mode = 1'b1;
            push_event(EV_BRIDGE_ON, 8'd0);
        end else if (word_match("esp_off", len)) begin
            reset_line_state();
            br_mode = 1'b0;
            push_event(EV_BRIDGE_OFF, 8'd0);
        end
    endfunction

    function automatic void bridge_rx(logic [7:0] b);
        if (b == CH_LF && skip_lf) begin
            skip_lf = 1'b0;
            return;
        end
        if (b == CH_CR || b == CH_LF) begin
            skip_lf = (b == CH_CR);
            if (line_len == 0) return;
            if (line_len == 3 && line_mem[0] == CH_PLUS && line_mem[1] == CH_PLUS &&
                line_mem[2] == CH_PLUS) begin
                plus_cnt = 0;
                line_len = 0;
                br_mode  = 1'b0;
                push_event(EV_BRIDGE_OFF, 8'd0);
                return;
            end
            for (int i = 0; i < line_len; i++) push_event(EV_BYTE, line_mem[i]);
            push_event(EV_BYTE, CH_CR);
            push_event(EV_BYTE, CH_LF);
            plus_cnt = 0;
            line_len = 0;
            return;
        end
        skip_lf = 1'b0;
        if (b == CH_PLUS) begin
            if (plus_cnt < int'(PLUS_SAT)) plus_cnt++;
        end else begin
            plus_cnt = 0;
        end
        if (line_len < LINE_DEPTH - 1) begin
            line_mem[line_len] = b;
            line_len++;
        end else begin
            line_len = 0;
            plus_cnt = 0;
            push_event(EV_DROP, 8'd0);
            return;
        end
        if (plus_cnt >= int'(PLUS_SAT) && line_len == 3) begin
            plus_cnt = 0;
            line_len = 0;
            br_mode  = 1'b0;
            push_event(EV_BRIDGE_OFF, 8'd0);
        end
    endfunction

    function automatic void command_rx(logic [7:0] b);
        int len;
        if (cmd_len >= CMD_DEPTH - 1) return;
        cmd_mem[cmd_len] = b;
        cmd_len++;
        idle_cnt = 0;
        if (b == CH_CR || b == CH_LF) begin
            len = cmd_len;
            if (len > 0 && cmd_mem[len-1] == CH_LF) len--;
            if (len > 0 && cmd_mem[len-1] == CH_CR) len--;
            finish_command(len);
            return;
        end
        if (cmd_len >= CMD_DEPTH - 1) finish_command(cmd_len);
    endfunction

    function automatic void predict_request(logic act, logic [7:0] b);
        req_results.delete();
        if (act == ACT_BYTE) begin
            if (br_mode) bridge_rx(b);
            else command_rx(b);
        end else if (cmd_len > 0) begin
            if (idle_cnt < IDLE_CNT_MAX) idle_cnt++;
            if (idle_cnt >= idle_limit) finish_command(cmd_len);
        end
        if (req_results.size() > 0) req_results[req_results.size()-1].last = 1'b1;
        foreach (req_results[i]) expected_q.push_back(req_results[i]);
    endfunction

    function automatic logic [7:0] rand_letter();
        return 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    task automatic send_req(input logic act, input logic [7:0] data);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.action  <= act;
        req_if.rx_data <= data;
        do @(posedge i_clk); while (!req_if.ready);
        predict_request(act, data);
        sent_cnt++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_req(ACT_BYTE, s[i]);
    endtask

    task automatic send_eol();
        t_eol kind;
        kind = t_eol'($urandom_range(0, 2));
        case (kind)
            EOL_CR: begin
                send_req(ACT_BYTE, CH_CR);
            end
            EOL_LF: begin
                send_req(ACT_BYTE, CH_LF);
            end
            default: begin
                send_req(ACT_BYTE, CH_CR);
                send_req(ACT_BYTE, CH_LF);
            end
        endcase
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++) send_req(ACT_TICK, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_random_bytes(input int n, input bit letters_only);
        for (int i = 0; i < n; i++) begin
            if (letters_only) send_req(ACT_BYTE, rand_letter());
            else send_req(ACT_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_until_idle();
        req_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_idle_limit(input logic [15:0] value);
        wait_until_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        idle_limit = value;
    endtask

    task automatic test_commands();
        send_text("start");
        send_req(ACT_BYTE, CH_LF);
        send_text("stop");
        send_req(ACT_BYTE, CH_CR);
        send_req(ACT_BYTE, CH_LF);
        send_text("esp_off");
        send_req(ACT_BYTE, CH_LF);
    endtask

    task automatic test_bridge_lines();
        send_text("at");
        send_req(ACT_BYTE, CH_CR);
        send_req(ACT_BYTE, 8'h00);
        send_req(ACT_BYTE, 8'hFF);
        send_req(ACT_BYTE, CH_CR);
        send_req(ACT_BYTE, CH_LF);
        send_req(ACT_BYTE, CH_LF);
        send_text("+++");
    endtask

    task automatic test_idle_timeout();
        write_idle_limit(16'd2);
        send_text("stop");
        send_ticks(2);
        write_idle_limit(16'd1);
        send_ticks(1);
        send_text("st");
        send_ticks(1);
    endtask

    task automatic test_random_traffic(input int count);
        int    stop_at;
        int    pick;
        int    n;
        string w;
        stop_at = sent_cnt + count;
        while (sent_cnt < stop_at) begin
            pick = $urandom_range(0, 9);
            if (br_mode) begin
                case (pick)
                    6: begin
                        send_random_bytes($urandom_range(29, 33), 1'b0);
                        send_eol();
                    end
                    7: send_text("+++");
                    8: begin
                        if ($urandom_range(0, 1) == 0) send_text("x+++");
                        else send_text("++");
                        send_eol();
                    end
                    9: send_ticks($urandom_range(1, 3));
                    default: begin
                        send_random_bytes($urandom_range(0, 12), 1'b0);
                        send_eol();
                    end
                endcase
            end else begin
                case (pick)
                    5: begin
                        w = cmd_words[$urandom_range(0, 5)];
                        n = $urandom_range(1, w.len());
                        for (int i = 0; i < n; i++) send_req(ACT_BYTE, w[i]);
                        send_ticks((idle_limit <= 8) ? idle_limit : $urandom_range(1, 4));
                    end
                    6: send_random_bytes($urandom_range(31, 33), 1'b1);
                    7: send_random_bytes($urandom_range(1, 3), 1'b0);
                    8: send_ticks($urandom_range(1, 3));
                    9: begin
                        send_text(cmd_words[2 + $urandom_range(0, 2)]);
                        send_eol();
                    end
                    default: begin
                        w = cmd_words[$urandom_range(0, 5)];
                        if ($urandom_range(0, 4) == 0) begin
                            w.putc($urandom_range(0, w.len() - 1), rand_letter());
                        end
                        send_text(w);
                        send_eol();
                    end
                endcase
            end
        end
    endtask

    task automatic test_long_timeout();
        idle_en = 1'b0;
        send_req(ACT_BYTE, CH_LF);
        if (br_mode) send_text("+++");
        write_idle_limit(16'hFFFF);
        send_text("stop");
        send_ticks(8);
        send_req(ACT_BYTE, CH_LF);
    endtask

    // result sink with random stalls
    initial begin : sink_proc
        int hold;
        hold = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                rsp_if.ready <= 1'b0;
            end else if (idle_en && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 6) - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result: event_kind %0d out_byte %0d last %0d",
                       rsp_if.event_kind, rsp_if.out_byte, rsp_if.last);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                if (rsp_if.event_kind !== want.kind) begin
                    $error("event_kind: expected %0d, got %0d", want.kind, rsp_if.event_kind);
                    err_cnt++;
                end
                if (rsp_if.out_byte !== want.data) begin
                    $error("out_byte: expected %0d, got %0d", want.data, rsp_if.out_byte);
                    err_cnt++;
                end
                if (rsp_if.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, rsp_if.last);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cnt = 0;
        end else begin
            quiet_cnt++;
        end
        if (quiet_cnt >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = 16'd0;
        req_if.valid   = 1'b0;
        req_if.action  = ACT_BYTE;
        req_if.rx_data = 8'd0;
        br_mode        = 1'b0;
        cmd_len        = 0;
        line_len       = 0;
        plus_cnt       = 0;
        skip_lf        = 1'b0;
        idle_cnt       = 0;
        idle_limit     = int'(TIMEOUT_RST);
        err_cnt        = 0;
        sent_cnt       = 0;
        quiet_cnt      = 0;
        idle_en        = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_bridge_lines();
        test_idle_timeout();
        write_idle_limit(16'd3);
        test_random_traffic(35);
        write_idle_limit(16'($urandom_range(4, 6)));
        test_random_traffic(30);
        write_idle_limit(16'd1);
        test_random_traffic(25);
        test_long_timeout();
        write_idle_limit(16'd2);
        test_random_traffic(25);
        wait_until_idle();

        if (err_cnt == 0 && expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
